>>> sv/lfs_pkg.sv
// shared types and constants for the led fade level sequencer
package lfs_pkg;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int SPD_W   = 8;   // ramp speed, signed tenths
    localparam int CFG_W   = 7;
    localparam int BR_W    = 13;  // stored brightness, signed tenths
    localparam int CALC_W  = 16;  // brightness arithmetic before saturation

    // register index decoded from paddr[2]
    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_MIN_SPEED = 1'b1;

    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 7'd20;
    localparam logic [CFG_W-1:0] MIN_SPEED_RST = 7'd1;
    localparam logic signed [SPD_W-1:0] SPEED_RST = 8'sd3;

    // brightness bands in tenths
    localparam logic signed [CALC_W-1:0] UP_BAND_1  = 16'sd300;
    localparam logic signed [CALC_W-1:0] UP_BAND_2  = 16'sd1000;
    localparam logic signed [CALC_W-1:0] UP_BAND_3  = 16'sd1650;
    localparam logic signed [CALC_W-1:0] TOP_LIMIT  = 16'sd2500;
    localparam logic signed [CALC_W-1:0] DN_BAND_9X = 16'sd1850;
    localparam logic signed [CALC_W-1:0] DN_BAND_5H = 16'sd1750;
    localparam logic signed [CALC_W-1:0] DN_BAND_5L = 16'sd1000;
    localparam logic signed [CALC_W-1:0] DN_BAND_2L = 16'sd200;
    localparam logic signed [CALC_W-1:0] BOT_LIMIT  = 16'sd5;
    localparam logic signed [CALC_W-1:0] RELOAD_VAL = 16'sd2550;
    localparam logic signed [CALC_W-1:0] BR_LOW     = -16'sd4096;
    localparam logic signed [CALC_W-1:0] BR_HIGH    = 16'sd4095;

    localparam logic [1:0] LEVEL_TOP = 2'd3;
    localparam logic [1:0] LEVEL_BOT = 2'd0;

    // duty = b / 10 for 0 <= b < 2550, by reciprocal multiply
    localparam logic [12:0] RECIP_10   = 13'd6554;
    localparam int          RECIP_SHFT = 16;
    localparam logic [7:0]  DUTY_MAX   = 8'd255;

    typedef struct packed {
        logic btn_faster;
        logic btn_slower;
    } t_in;

    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] level_bits;
        logic       level_update;
        logic       going_up;
    } t_out;

endpackage

>>> sv/lfs_cfg_regs.sv
// apb register block holding the speed ceiling and floor
module lfs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [lfs_pkg::DATA_W-1:0]    pwdata,
    output logic [lfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [lfs_pkg::CFG_W-1:0]     o_max_speed,
    output logic [lfs_pkg::CFG_W-1:0]     o_min_speed
);

    logic [lfs_pkg::CFG_W-1:0] r_max_speed;
    logic [lfs_pkg::CFG_W-1:0] r_min_speed;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= lfs_pkg::MAX_SPEED_RST;
            r_min_speed <= lfs_pkg::MIN_SPEED_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                lfs_pkg::REG_MAX_SPEED: r_max_speed <= pwdata[lfs_pkg::CFG_W-1:0];
                lfs_pkg::REG_MIN_SPEED: r_min_speed <= pwdata[lfs_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            lfs_pkg::REG_MAX_SPEED: prdata[lfs_pkg::CFG_W-1:0] = r_max_speed;
            lfs_pkg::REG_MIN_SPEED: prdata[lfs_pkg::CFG_W-1:0] = r_min_speed;
            default: prdata = '0;
        endcase
    end

    assign o_max_speed = r_max_speed;
    assign o_min_speed = r_min_speed;

endmodule

>>> sv/lfs_speed_ctl.sv
// button edge detection and ramp speed register
module lfs_speed_ctl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  lfs_pkg::t_in                      i_item,
    input  logic [lfs_pkg::CFG_W-1:0]         i_max_speed,
    input  logic [lfs_pkg::CFG_W-1:0]         i_min_speed,
    output logic signed [lfs_pkg::SPD_W-1:0]  o_speed
);

    logic signed [lfs_pkg::SPD_W-1:0] r_speed;
    logic signed [lfs_pkg::SPD_W-1:0] n_speed;
    logic signed [lfs_pkg::SPD_W-1:0] spd_mid;
    logic                             r_faster_held;
    logic                             r_slower_held;
    logic signed [lfs_pkg::SPD_W:0]   max_s;
    logic signed [lfs_pkg::SPD_W:0]   min_s;

    assign max_s = $signed({2'b00, i_max_speed});
    assign min_s = $signed({2'b00, i_min_speed});

    always_comb begin
        spd_mid = r_speed;
        if (i_item.btn_faster && !r_faster_held &&
            ($signed({r_speed[lfs_pkg::SPD_W-1], r_speed}) < max_s)) begin
            spd_mid = r_speed + 8'sd2;
        end
        n_speed = spd_mid;
        if (i_item.btn_slower && !r_slower_held &&
            ($signed({spd_mid[lfs_pkg::SPD_W-1], spd_mid}) > min_s)) begin
            n_speed = spd_mid - 8'sd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed       <= lfs_pkg::SPEED_RST;
            r_faster_held <= 1'b0;
            r_slower_held <= 1'b0;
        end else if (i_en) begin
            r_speed       <= n_speed;
            r_faster_held <= i_item.btn_faster;
            r_slower_held <= i_item.btn_slower;
        end
    end

    // the ramp uses the speed after this beat's button edges
    assign o_speed = n_speed;

endmodule

>>> sv/lfs_ramp.sv
// brightness ramp, level stepping and duty conversion
module lfs_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic signed [lfs_pkg::SPD_W-1:0]  i_speed,
    output lfs_pkg::t_out                     o_result
);

    localparam int CW = lfs_pkg::CALC_W;

    logic signed [lfs_pkg::BR_W-1:0] r_bright;
    logic [1:0]                      r_level;
    logic                            r_rising;
    logic                            r_dirty;

    logic signed [CW-1:0] b;
    logic signed [CW-1:0] v1;
    logic signed [CW-1:0] v2;
    logic signed [CW-1:0] v5;
    logic signed [CW-1:0] v9;
    logic signed [CW-1:0] b_dn;
    logic signed [CW-1:0] b_new;
    logic signed [CW-1:0] b_sat;
    logic [1:0]           n_level;
    logic                 n_rising;
    logic                 n_dirty;
    logic [11:0]          b_low;
    logic [24:0]          prod;
    logic [7:0]           duty;

    assign b  = CW'(r_bright);
    assign v1 = CW'(i_speed);
    assign v2 = v1 <<< 1;
    assign v5 = (v1 <<< 2) + v1;
    assign v9 = (v1 <<< 3) + v1;

    always_comb begin
        n_level  = r_level;
        n_rising = r_rising;
        n_dirty  = r_dirty;
        b_dn     = b;
        b_new    = b;
        if (r_rising) begin
            if (b < lfs_pkg::UP_BAND_1)      b_new = b + v1;
            else if (b < lfs_pkg::UP_BAND_2) b_new = b + v2;
            else if (b < lfs_pkg::UP_BAND_3) b_new = b + v5;
            else                             b_new = b + v9;
            if (b_new >= lfs_pkg::TOP_LIMIT) begin
                if (r_level == lfs_pkg::LEVEL_TOP) begin
                    n_rising = ~r_rising;
                end else begin
                    n_level = r_level + 2'd1;
                    b_new   = '0;
                end
                n_dirty = 1'b1;
            end
        end else begin
            // top band loses 9x first, then falls into the lower bands
            if (b >= lfs_pkg::DN_BAND_9X) b_dn = b - v9;
            if (b_dn >= lfs_pkg::DN_BAND_5L && b_dn < lfs_pkg::DN_BAND_5H)
                b_new = b_dn - v5;
            else if (b_dn >= lfs_pkg::DN_BAND_2L && b_dn < lfs_pkg::DN_BAND_5L)
                b_new = b_dn - v2;
            else
                b_new = b_dn - v1;
            if (b_new <= lfs_pkg::BOT_LIMIT) begin
                if (r_level == lfs_pkg::LEVEL_BOT) begin
                    n_rising = ~r_rising;
                end else begin
                    n_level = r_level - 2'd1;
                    b_new   = lfs_pkg::RELOAD_VAL;
                end
                n_dirty = 1'b1;
            end
        end
        if (b_new < lfs_pkg::BR_LOW)       b_sat = lfs_pkg::BR_LOW;
        else if (b_new > lfs_pkg::BR_HIGH) b_sat = lfs_pkg::BR_HIGH;
        else                               b_sat = b_new;
    end

    assign b_low = b_sat[11:0];
    assign prod  = 25'(b_low) * 25'(lfs_pkg::RECIP_10);

    always_comb begin
        if (b_sat < 0)                            duty = '0;
        else if (b_sat >= lfs_pkg::RELOAD_VAL)    duty = lfs_pkg::DUTY_MAX;
        else                                      duty = prod[lfs_pkg::RECIP_SHFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
            r_level  <= lfs_pkg::LEVEL_BOT;
            r_rising <= 1'b1;
            r_dirty  <= 1'b1;
        end else if (i_en) begin
            r_bright <= b_sat[lfs_pkg::BR_W-1:0];
            r_level  <= n_level;
            r_rising <= n_rising;
            r_dirty  <= 1'b0;
        end
    end

    assign o_result.duty         = duty;
    assign o_result.level_bits   = n_level;
    assign o_result.level_update = n_dirty;
    assign o_result.going_up     = n_rising;

endmodule

>>> sv/led_fade_level_sequencer.sv
// led fade level sequencer top level: input stage, state update and output register
// an accepted beat is held in the input register, and its result then in the output register
// throughput: one beat per cycle while i_stall is low; speed and ramp state update together
// while a finished result waits on i_stall the input register takes one more beat, then stalls
// reset (synchronous, active low): speed 3 tenths, brightness 0, level 0, rising,
// level pins flagged for rewrite, max_speed 20, min_speed 1, both stages empty
module led_fade_level_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  lfs_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output lfs_pkg::t_out                 o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfs_pkg::ADDR_W-1:0]    paddr,
    input  logic [lfs_pkg::DATA_W-1:0]    pwdata,
    output logic [lfs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                             r_s1_v;
    lfs_pkg::t_in                     r_s1_data;
    logic                             r_out_v;
    lfs_pkg::t_out                    r_out_data;
    logic                             in_take;
    logic                             s1_go;
    logic [lfs_pkg::CFG_W-1:0]        max_speed;
    logic [lfs_pkg::CFG_W-1:0]        min_speed;
    logic signed [lfs_pkg::SPD_W-1:0] speed;
    lfs_pkg::t_out                    result;

    lfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_speed (max_speed),
        .o_min_speed (min_speed)
    );

    lfs_speed_ctl u_speed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_go),
        .i_item      (r_s1_data),
        .i_max_speed (max_speed),
        .i_min_speed (min_speed),
        .o_speed     (speed)
    );

    lfs_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s1_go),
        .i_speed  (speed),
        .o_result (result)
    );

    // the held beat moves on when the output register is empty or being taken
    assign s1_go   = r_s1_v && (!r_out_v || !i_stall);
    assign o_stall = r_s1_v && !s1_go;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_take)    r_s1_v <= 1'b1;
            else if (s1_go) r_s1_v <= 1'b0;
            if (s1_go)         r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_s1_data  <= i_data;
        if (s1_go)   r_out_data <= result;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_data;

endmodule

>>> sv/lfs_checker.sv
// port-level checks for the led fade level sequencer, bound to the top level
module lfs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  lfs_pkg::t_out                 o_data,
    input  logic                          psel,
    input  logic                          pwrite,
    input  logic [lfs_pkg::DATA_W-1:0]    prdata
);

    // a waiting result holds its beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // with nothing waiting at the output the input side never stalls
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty output");

    // leaving reset, no result is pending
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // speed registers are seven bits wide, upper read bits stay zero
    a_read_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite |-> prdata[lfs_pkg::DATA_W-1:lfs_pkg::CFG_W] == '0)
        else $error("register read shows bits above the field");

endmodule

bind led_fade_level_sequencer lfs_checker u_lfs_checker (.*);
